[hdl/upd_pkg.sv]
// shared types, constants and hex helpers for the url percent decoder
// used by every module of the decoder; depends on nothing

package upd_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] PCT_CHAR = 8'h25;

   typedef enum logic [1:0] {
      PHASE_PLAIN = 2'd0,
      PHASE_PCT   = 2'd1,
      PHASE_DIGIT = 2'd2
   } phase_type;

   // one request's output bytes, chars[0] goes out first
   typedef struct packed {
      logic [1:0]      count;
      logic [2:0][7:0] chars;
   } cmd_type;

   typedef struct packed {
      phase_type phase;
      logic      push;
   } front_status_type;

   function automatic logic hex_ok(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] t;
      if (c >= 8'h30 && c <= 8'h39) begin
         t = c - 8'h30;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         t = c - 8'h57;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         t = c - 8'h37;
      end else begin
         t = 8'h00;
      end
      return t[3:0];
   endfunction

endpackage

[hdl/url_percent_decoder_top.sv]
// url percent decoder top level: front end, command queue and back end
// depends on upd_pkg, upd_front, upd_queue and upd_back
//
// Takes one request byte per cycle (tlast marks the end of a string) and
// returns the decoded bytes, tlast on the final byte caused by each request.
// A request yields zero to three result bytes; the back end drains them at
// one byte per cycle while the receiver is ready; a new request is accepted
// every cycle that the QUEUE_DEPTH-entry front-to-back command queue is not full.
// A request's result bytes are written into the command queue, then loaded
// into the result register. A '%' that is still open when a string ends is dropped.

module url_percent_decoder_top #(
   parameter int QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // end_of_string
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast    // run_last
);
   import upd_pkg::*;

   cmd_type          push_cmd;
   cmd_type          head_cmd;
   front_status_type front_status;
   logic             q_full;
   logic             q_empty;
   logic             q_pop;

   upd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .push_cmd   (push_cmd),
      .status     (front_status)
   );

   upd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_status.push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   upd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .head_cmd   (head_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // a '%' in plain text opens an escape unless the string ends there
   a_pct_opens: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && front_status.phase == PHASE_PLAIN &&
       req_tdata == PCT_CHAR && !req_tlast) |=> front_status.phase == PHASE_PCT)
      else $error("percent did not open an escape");

   // end of string always returns to plain text
   a_eos_plain: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> front_status.phase == PHASE_PLAIN)
      else $error("escape left open after end of string");

   // the back end never pops an empty queue
   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("pop from empty command queue");

   // a push never lands in a full queue
   a_push_full: assert property (@(posedge clock) disable iff (reset)
      front_status.push |-> !q_full)
      else $error("push into full command queue");

endmodule

[hdl/upd_front.sv]
// front end: accepts request bytes, tracks the escape phase and builds
// one output command per request; depends on upd_pkg

module upd_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,  // [7:0] in_byte
   input  logic                      req_tlast,  // end_of_string
   input  logic                      q_full,
   output upd_pkg::cmd_type          push_cmd,
   output upd_pkg::front_status_type status
);
   import upd_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [7:0] held_ff, held_in;
   logic       accept;
   cmd_type    cmd;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;

   // next state
   always_comb begin
      phase_in = phase_ff;
      held_in  = held_ff;
      if (accept) begin
         case (phase_ff)
            PHASE_PCT: begin
               if (hex_ok(req_tdata)) begin
                  phase_in = PHASE_DIGIT;
                  held_in  = req_tdata;
               end else begin
                  phase_in = PHASE_PLAIN;
               end
            end
            PHASE_DIGIT: begin
               phase_in = PHASE_PLAIN;
            end
            default: begin
               if (req_tdata == PCT_CHAR) begin
                  phase_in = PHASE_PCT;
                  held_in  = 8'h00;
               end else begin
                  phase_in = PHASE_PLAIN;
               end
            end
         endcase
         if (req_tlast) begin
            phase_in = PHASE_PLAIN;
            held_in  = 8'h00;
         end
      end
   end

   // outputs
   always_comb begin
      cmd.count = 2'd0;
      cmd.chars = '0;
      case (phase_ff)
         PHASE_PCT: begin
            if (!hex_ok(req_tdata)) begin
               cmd.count    = 2'd2;
               cmd.chars[0] = PCT_CHAR;
               cmd.chars[1] = req_tdata;
            end
         end
         PHASE_DIGIT: begin
            if (hex_ok(req_tdata)) begin
               cmd.count    = 2'd1;
               cmd.chars[0] = {hex_val(held_ff), hex_val(req_tdata)};
            end else begin
               cmd.count    = 2'd3;
               cmd.chars[0] = PCT_CHAR;
               cmd.chars[1] = held_ff;
               cmd.chars[2] = req_tdata;
            end
         end
         default: begin
            if (req_tdata != PCT_CHAR) begin
               cmd.count    = 2'd1;
               cmd.chars[0] = req_tdata;
            end
         end
      endcase
   end

   assign push_cmd     = cmd;
   assign status.push  = accept && (cmd.count != 2'd0);
   assign status.phase = phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_PLAIN;
         held_ff  <= 8'h00;
      end else begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

endmodule

[hdl/upd_queue.sv]
// short command queue between front end and back end
// depends on upd_pkg

module upd_queue #(
   parameter int DEPTH = upd_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  upd_pkg::cmd_type push_cmd,
   input  logic             pop,
   output upd_pkg::cmd_type head_cmd,
   output logic             full,
   output logic             empty
);
   import upd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;

   assign full     = (fill_ff == CNT_W'(DEPTH));
   assign empty    = (fill_ff == '0);
   assign head_cmd = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[hdl/upd_back.sv]
// back end: drains queued commands one byte per cycle, while the receiver
// is ready, into the registered result channel; depends on upd_pkg

module upd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  upd_pkg::cmd_type head_cmd,
   output logic             q_pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,  // [7:0] out_byte
   output logic             rsp_tlast   // run_last
);
   import upd_pkg::*;

   logic [1:0] index_ff, index_in;
   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       last_ff, last_in;
   logic       load;
   logic       is_last;

   assign load    = !q_empty && (!valid_ff || rsp_tready);
   assign is_last = (index_ff == head_cmd.count - 2'd1);
   assign q_pop   = load && is_last;

   always_comb begin
      index_in = index_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = head_cmd.chars[index_ff];
         last_in  = is_last;
         index_in = is_last ? 2'd0 : index_ff + 2'd1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         index_ff <= index_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

[test/testbench.sv]
// testbench for url_percent_decoder_top: directed escapes, random streams, output stall
// depends on upd_pkg and the decoder rtl; predicts the decoded bytes itself

module testbench;

   import upd_pkg::*;

   typedef struct {
      logic [7:0] value;
      logic       ends_run;
   } decoded_char_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;

   decoded_char_type expected_chars[$];
   phase_type        dec_phase = PHASE_PLAIN;
   logic [7:0]       dec_held = 8'h00;

   int    send_idle_pct = 0;
   int    recv_stall_pct = 0;
   int    hold_cycles = 0;
   int    mismatch_count = 0;
   int    requests_sent = 0;
   int    chars_checked = 0;
   string hex_chars = "0123456789abcdefABCDEF";
   string edge_chars = "/:@G`g";

   url_percent_decoder_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("timeout: decoder stopped making progress");
      $display("tb: failure");
      $finish;
   end

   task automatic flag_mismatch(input string what);
      if (mismatch_count < 50) begin
         $display("mismatch at %0t: %s", $time, what);
      end
      mismatch_count++;
   endtask

   function automatic logic hex_char_ok(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   // digits keep their value in the low nibble, letters sit 9 below it
   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      return (c <= "9") ? c[3:0] : c[3:0] + 4'd9;
   endfunction

   function automatic void decode_request(input logic [7:0] c, input logic eos);
      logic [7:0] outs[$];
      case (dec_phase)
         PHASE_PCT: begin
            if (hex_char_ok(c)) begin
               dec_held = c;
               dec_phase = PHASE_DIGIT;
            end else begin
               outs.push_back(PCT_CHAR);
               outs.push_back(c);
               dec_phase = PHASE_PLAIN;
            end
         end
         PHASE_DIGIT: begin
            if (hex_char_ok(c)) begin
               outs.push_back({nibble_of(dec_held), nibble_of(c)});
            end else begin
               outs.push_back(PCT_CHAR);
               outs.push_back(dec_held);
               outs.push_back(c);
            end
            dec_phase = PHASE_PLAIN;
         end
         default: begin
            if (c == PCT_CHAR) begin
               dec_phase = PHASE_PCT;
               dec_held = 8'h00;
            end else begin
               outs.push_back(c);
               dec_phase = PHASE_PLAIN;
            end
         end
      endcase
      if (eos) begin
         dec_phase = PHASE_PLAIN;
         dec_held = 8'h00;
      end
      foreach (outs[k]) begin
         expected_chars.push_back('{value: outs[k], ends_run: (k == outs.size() - 1)});
      end
   endfunction

   task automatic send_char(input logic [7:0] c, input logic eos);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= c;
      req_tlast <= eos;
      do @(posedge clock); while (!req_tready);
      decode_request(c, eos);
      requests_sent++;
   endtask

   task automatic wait_drained();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (expected_chars.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      if (expected_chars.size() != 0) begin
         flag_mismatch($sformatf("%0d result bytes never arrived", expected_chars.size()));
         expected_chars.delete();
      end
      repeat (8) @(posedge clock);
   endtask

   function automatic logic rand_eos();
      return $urandom_range(7) == 0;
   endfunction

   function automatic logic [7:0] hex_pick();
      return hex_chars[$urandom_range(hex_chars.len() - 1)];
   endfunction

   function automatic logic [7:0] odd_pick();
      if ($urandom_range(1) == 0) begin
         return edge_chars[$urandom_range(edge_chars.len() - 1)];
      end
      return 8'($urandom_range(255));
   endfunction

   // well-formed escapes between plain bytes, plus broken and cut-off ones
   task automatic random_stream(input int n);
      int sent;
      int shape;
      sent = 0;
      while (sent < n) begin
         shape = $urandom_range(9);
         case (shape)
            0, 1, 2, 3: begin
               send_char(8'($urandom_range(255)), rand_eos());
               sent += 1;
            end
            4, 5, 6: begin
               send_char(PCT_CHAR, 1'b0);
               send_char(hex_pick(), 1'b0);
               send_char(hex_pick(), rand_eos());
               sent += 3;
            end
            7: begin
               send_char(PCT_CHAR, 1'b0);
               send_char(odd_pick(), rand_eos());
               sent += 2;
            end
            8: begin
               send_char(PCT_CHAR, 1'b0);
               send_char(hex_pick(), 1'b0);
               send_char(odd_pick(), rand_eos());
               sent += 3;
            end
            default: begin
               if ($urandom_range(1) == 0) begin
                  send_char(PCT_CHAR, 1'b1);
                  sent += 1;
               end else begin
                  send_char(PCT_CHAR, 1'b0);
                  send_char(hex_pick(), 1'b1);
                  sent += 2;
               end
            end
         endcase
      end
   endtask

   task automatic test_directed();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_char(8'h00, 1'b0);
      send_char(8'hff, 1'b0);
      // full escapes, upper and lower case
      send_char(PCT_CHAR, 1'b0);
      send_char("4", 1'b0);
      send_char("1", 1'b0);
      send_char(PCT_CHAR, 1'b0);
      send_char("a", 1'b0);
      send_char("F", 1'b1);
      // non-hex right after the percent
      send_char(PCT_CHAR, 1'b0);
      send_char("/", 1'b0);
      // non-hex second digit
      send_char(PCT_CHAR, 1'b0);
      send_char("9", 1'b0);
      send_char("g", 1'b0);
      // percent ending a failed escape opens nothing
      send_char(PCT_CHAR, 1'b0);
      send_char(PCT_CHAR, 1'b0);
      send_char("0", 1'b0);
      send_char(PCT_CHAR, 1'b0);
      send_char("f", 1'b0);
      send_char(PCT_CHAR, 1'b0);
      send_char("4", 1'b0);
      // escape cut off by end of string
      send_char(PCT_CHAR, 1'b1);
      send_char(PCT_CHAR, 1'b0);
      send_char("A", 1'b1);
      send_char("@", 1'b1);
      wait_drained();
   endtask

   task automatic test_random_idle();
      int mix;
      for (mix = 0; mix < 4; mix++) begin
         send_idle_pct = (mix == 1) ? 60 : (mix == 3) ? 36 : 0;
         recv_stall_pct = (mix == 2) ? 60 : (mix == 3) ? 36 : 0;
         random_stream(15);
         wait_drained();
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_cycles = 400;
      random_stream(24);
      wait_drained();
   endtask

   // receiver side: random stalls, or one long hold-off when asked
   initial begin
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      decoded_char_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_chars.size() == 0) begin
            flag_mismatch($sformatf("unexpected result byte %02h", rsp_tdata));
         end else begin
            want = expected_chars.pop_front();
            if (rsp_tdata !== want.value) begin
               flag_mismatch($sformatf("out_byte %02h, want %02h", rsp_tdata, want.value));
            end
            if (rsp_tlast !== want.ends_run) begin
               flag_mismatch($sformatf("run_last %b, want %b", rsp_tlast, want.ends_run));
            end
            chars_checked++;
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_idle();
      test_backpressure();
      $display("sent %0d requests, checked %0d decoded bytes", requests_sent, chars_checked);
      $display("covered escapes, broken escapes, cut-off strings, idle mixes and a long stall");
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
